FILE: src/tcpfw_pkg.sv
// Package with the shared types and constants of the TCP connection state firewall.
`default_nettype none

package tcpfw_pkg;

    localparam int ID_W          = 10;
    localparam int PROTO_W       = 8;
    localparam int NUM_CONNS_DEF = 1024;

    localparam logic [PROTO_W-1:0] PROTO_TCP = '0;

    typedef enum logic [1:0] {
        CS_NULL = 2'd0,
        CS_NEW  = 2'd1,
        CS_EST  = 2'd2,
        CS_INV  = 2'd3
    } t_conn_state;

    typedef enum logic [1:0] {
        CTL_CLEAR = 2'b01,
        CTL_RUN   = 2'b10
    } t_ctl_state;

    typedef struct packed {
        logic [ID_W-1:0]    conn_id;
        logic [PROTO_W-1:0] proto;
        logic               syn_flag;
        logic               ack_flag;
        logic               fin_flag;
        logic               from_client;
        logic               timeout_mark;
        logic               dropped_in;
    } t_pkt_in;

    typedef struct packed {
        logic [ID_W-1:0] conn_id_out;
        logic            dropped;
        t_conn_state     state_after;
    } t_pkt_out;

endpackage

`default_nettype wire

FILE: src/tcp_connection_state_firewall.sv
// Top level of the TCP connection state firewall: lookup stage, decision stage and result register.
// The block takes one packet beat per clock while o_ready is high. An accepted beat is registered
// in the decision stage with its table read, and its result moves into the result register when
// that register is free or being taken. Each beat does a single read-modify-write of the state
// table, with the last write forwarded. After reset the table is cleared one entry per cycle, so
// the input stays not ready until the clearing sweep has finished. Connection indexes at or above
// NUM_CONNS are reduced modulo NUM_CONNS to pick the entry; the result echoes the unreduced index.
`default_nettype none

module tcp_connection_state_firewall
    import tcpfw_pkg::*;
#(
    parameter int NUM_CONNS = NUM_CONNS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_pkt_in   i_pkt,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_pkt_out  o_pkt
);

    localparam int IDX_W    = $clog2(NUM_CONNS);
    localparam int RECIP_S  = ID_W + IDX_W;
    localparam int RECIP_MW = ID_W + 2;
    localparam int PROD_W   = ID_W + RECIP_MW;
    localparam logic [RECIP_MW-1:0] RECIP_M =
        RECIP_MW'(((longint'(1) << RECIP_S) + longint'(NUM_CONNS) - longint'(1))
                  / longint'(NUM_CONNS));

    logic              accept;
    logic              s1_adv;
    logic              mem_busy;
    logic [PROD_W-1:0] recip_prod;
    logic [ID_W-1:0]   quot;
    logic [ID_W-1:0]   rem;
    logic [IDX_W-1:0]  rd_idx;
    t_conn_state       rd_state;
    t_conn_state       cur_state;
    t_conn_state       nxt_state;
    logic              drop;

    logic             r_s1_valid;
    t_pkt_in          r_s1_pkt;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s1_fw_hit;
    t_conn_state      r_s1_fw_state;
    logic             r_out_valid;
    t_pkt_out         r_out_pkt;

    // The entry index is the connection index modulo the table depth, taken through a
    // multiply by the reciprocal of the depth.
    assign recip_prod = PROD_W'(i_pkt.conn_id) * PROD_W'(RECIP_M);
    assign quot       = ID_W'(recip_prod >> RECIP_S);
    assign rem        = i_pkt.conn_id - ID_W'(quot * NUM_CONNS);

    assign rd_idx  = IDX_W'(rem);
    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !mem_busy && (!r_s1_valid || s1_adv);
    assign accept  = i_valid && o_ready;

    tcpfw_state_mem #(
        .NUM_CONNS (NUM_CONNS),
        .IDX_W     (IDX_W)
    ) u_state_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_idx   (rd_idx),
        .o_rd_state (rd_state),
        .i_wr_en    (s1_adv),
        .i_wr_idx   (r_s1_idx),
        .i_wr_state (nxt_state),
        .o_busy     (mem_busy)
    );

    assign cur_state = r_s1_fw_hit ? r_s1_fw_state : rd_state;

    always_comb begin
        nxt_state = cur_state;
        drop      = r_s1_pkt.dropped_in;
        case (cur_state)
            CS_NULL: begin
                if (r_s1_pkt.proto != PROTO_TCP) begin
                    nxt_state = CS_NULL;
                end else if (r_s1_pkt.syn_flag && !r_s1_pkt.ack_flag
                             && r_s1_pkt.from_client) begin
                    nxt_state = CS_NEW;
                end else begin
                    nxt_state = CS_INV;
                    drop      = 1'b1;
                end
            end
            CS_NEW: begin
                if (r_s1_pkt.syn_flag && r_s1_pkt.ack_flag && !r_s1_pkt.from_client) begin
                    nxt_state = CS_EST;
                end else if (r_s1_pkt.timeout_mark) begin
                    nxt_state = CS_NULL;
                end else begin
                    nxt_state = CS_INV;
                    drop      = 1'b1;
                end
            end
            CS_EST: begin
                if (r_s1_pkt.fin_flag || r_s1_pkt.timeout_mark) begin
                    nxt_state = CS_NULL;
                end
            end
            default: begin
                if (r_s1_pkt.timeout_mark) begin
                    nxt_state = CS_NULL;
                end else begin
                    drop = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pkt      <= i_pkt;
            r_s1_idx      <= rd_idx;
            r_s1_fw_hit   <= s1_adv && (r_s1_idx == rd_idx);
            r_s1_fw_state <= nxt_state;
        end
        if (s1_adv) begin
            r_out_pkt.conn_id_out <= r_s1_pkt.conn_id;
            r_out_pkt.dropped     <= drop;
            r_out_pkt.state_after <= nxt_state;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pkt   = r_out_pkt;

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("Accepted beat did not reach the decision stage.");

    a_invalid_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_pkt.state_after == CS_INV)) |-> r_out_pkt.dropped)
        else $error("Result in the invalid state was not dropped.");

    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_busy |-> (!o_ready && !r_s1_valid))
        else $error("Table access while the clearing sweep runs.");

    a_stage_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("Decision stage advanced without a result.");

endmodule

`default_nettype wire

FILE: src/tcpfw_state_mem.sv
// Connection state table with one read port, one write port and a clearing sweep after reset.
`default_nettype none

module tcpfw_state_mem
    import tcpfw_pkg::*;
#(
    parameter int NUM_CONNS = NUM_CONNS_DEF,
    parameter int IDX_W     = $clog2(NUM_CONNS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_idx,
    output t_conn_state           o_rd_state,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_idx,
    input  t_conn_state           i_wr_state,
    output logic                  o_busy
);

    t_conn_state      r_mem [NUM_CONNS];
    t_conn_state      r_rd_state;
    t_ctl_state       r_ctl;
    t_ctl_state       n_ctl;
    logic [IDX_W-1:0] r_clr_addr;
    logic [IDX_W-1:0] n_clr_addr;
    logic             clr_last;

    assign clr_last = (r_clr_addr == IDX_W'(NUM_CONNS - 1));

    always_comb begin
        n_ctl      = r_ctl;
        n_clr_addr = r_clr_addr;
        case (r_ctl)
            CTL_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (clr_last) begin
                    n_ctl = CTL_RUN;
                end
            end
            CTL_RUN: begin
                n_clr_addr = '0;
            end
            default: begin
                n_ctl      = CTL_CLEAR;
                n_clr_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl      <= CTL_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_ctl      <= n_ctl;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl == CTL_CLEAR) begin
            r_mem[r_clr_addr] <= CS_NULL;
        end else if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_state;
        end
        if (i_rd_en) begin
            r_rd_state <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_state = r_rd_state;
    assign o_busy     = (r_ctl != CTL_RUN);

endmodule

`default_nettype wire
